/* hdl/rc4_pkg.sv */
// Package for the RC4 stream cipher: command codes from the controller,
// datapath status, configuration register indexes and fixed constants.
// No dependencies; imported by rc4_ctrl, rc4_dp and the top level.
package rc4_pkg;

    localparam int unsigned C_PERM_DEPTH    = 256;
    localparam int unsigned C_MAX_KEY_BYTES = 32;
    localparam int unsigned C_CFG_IDX_W     = 3;
    localparam int unsigned C_CFG_DATA_W    = 64;

    // Configuration register indexes.
    localparam logic [C_CFG_IDX_W-1:0] CFG_KEY_BYTES_0_7   = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_KEY_BYTES_8_15  = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_KEY_BYTES_16_23 = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] CFG_KEY_BYTES_24_31 = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] CFG_KEY_LENGTH      = 3'd4;

    // One command per cycle from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD_SCHED,
        CMD_LOAD_GEN,
        CMD_FILL,
        CMD_KS_RD_K,
        CMD_KS_RD_J,
        CMD_KS_WR_K,
        CMD_KS_WR_J,
        CMD_GEN_RD_I,
        CMD_GEN_RD_J,
        CMD_GEN_WR_I,
        CMD_GEN_WR_J
    } t_cmd;

    typedef struct packed {
        logic i_last;    // index i is at its last value, 255
        logic out_free;  // output register can take a result this cycle
    } t_dp_status;

endpackage

/* hdl/rc4_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rc4_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/rc4_ctrl.sv */
// Controller for the RC4 stream cipher: sequences permutation fill, key
// schedule rounds and per-byte generation. Depends on rc4_pkg.
module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_first,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD_K,
        ST_KS_RD_J,
        ST_KS_WR_K,
        ST_KS_WR_J,
        ST_GEN_RD_I,
        ST_GEN_RD_J,
        ST_GEN_WR_I,
        ST_GEN_WR_J
    } t_state;

    t_state r_state;
    logic   r_scheduled;
    logic   w_need_sched;

    // A byte arriving before any schedule has run is handled as a first byte.
    assign w_need_sched = i_first || !r_scheduled;
    assign o_in_ready   = (r_state == ST_IDLE);

    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd = w_need_sched ? CMD_LOAD_SCHED : CMD_LOAD_GEN;
                end else begin
                    o_cmd = CMD_NONE;
                end
            end
            ST_FILL:     o_cmd = CMD_FILL;
            ST_KS_RD_K:  o_cmd = CMD_KS_RD_K;
            ST_KS_RD_J:  o_cmd = CMD_KS_RD_J;
            ST_KS_WR_K:  o_cmd = CMD_KS_WR_K;
            ST_KS_WR_J:  o_cmd = CMD_KS_WR_J;
            ST_GEN_RD_I: o_cmd = CMD_GEN_RD_I;
            ST_GEN_RD_J: o_cmd = CMD_GEN_RD_J;
            ST_GEN_WR_I: o_cmd = CMD_GEN_WR_I;
            ST_GEN_WR_J: o_cmd = CMD_GEN_WR_J;
            default:     o_cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scheduled <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        if (w_need_sched) begin
                            r_state     <= ST_FILL;
                            r_scheduled <= 1'b1;
                        end else begin
                            r_state <= ST_GEN_RD_I;
                        end
                    end
                end
                ST_FILL: begin
                    if (i_status.i_last) begin
                        r_state <= ST_KS_RD_K;
                    end
                end
                ST_KS_RD_K: r_state <= ST_KS_RD_J;
                ST_KS_RD_J: r_state <= ST_KS_WR_K;
                ST_KS_WR_K: r_state <= ST_KS_WR_J;
                ST_KS_WR_J: begin
                    r_state <= i_status.i_last ? ST_GEN_RD_I : ST_KS_RD_K;
                end
                ST_GEN_RD_I: r_state <= ST_GEN_RD_J;
                ST_GEN_RD_J: r_state <= ST_GEN_WR_I;
                ST_GEN_WR_I: r_state <= ST_GEN_WR_J;
                ST_GEN_WR_J: begin
                    if (i_status.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

/* hdl/rc4_dp.sv */
// Datapath for the RC4 stream cipher: key registers, indices, the permutation
// memory and the output register. Depends on rc4_pkg and rc4_ram.
module rc4_dp
    import rc4_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                    i_cmd,
    input  logic [7:0]              i_data,
    input  logic                    i_out_ready,
    output t_dp_status              o_status,
    output logic                    o_out_valid,
    output logic [7:0]              o_out_data
);

    localparam int unsigned KPOS_W = $clog2(C_MAX_KEY_BYTES);
    localparam int unsigned LEN_W  = 6;

    logic [C_CFG_DATA_W-1:0] r_key [4];
    logic [LEN_W-1:0]        r_key_len;

    logic [7:0]        r_i, n_i;
    logic [7:0]        r_j, n_j;
    logic [KPOS_W-1:0] r_kpos, n_kpos;
    logic [7:0]        r_si, n_si;
    logic [7:0]        r_sj, n_sj;
    logic [7:0]        r_t, n_t;
    logic [7:0]        r_data, n_data;
    logic [7:0]        r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [4*C_CFG_DATA_W-1:0] w_key_flat;
    logic [7:0]                w_key_byte;
    logic [LEN_W-1:0]          w_len_eff;
    logic                      w_kpos_wrap;
    logic                      w_out_free;
    logic [7:0]                w_ks;

    logic       w_we;
    logic [7:0] w_waddr, w_wdata, w_raddr, w_rdata;

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (C_PERM_DEPTH)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_key_flat = {r_key[3], r_key[2], r_key[1], r_key[0]};
    assign w_key_byte = w_key_flat[{r_kpos, 3'b000} +: 8];

    // A zero length counts as one byte; lengths above the key store saturate.
    always_comb begin
        if (r_key_len == '0) begin
            w_len_eff = LEN_W'(1);
        end else if (r_key_len > LEN_W'(C_MAX_KEY_BYTES)) begin
            w_len_eff = LEN_W'(C_MAX_KEY_BYTES);
        end else begin
            w_len_eff = r_key_len;
        end
    end

    assign w_kpos_wrap = ({1'b0, r_kpos} == (w_len_eff - LEN_W'(1)));
    assign w_out_free  = !r_out_valid || i_out_ready;

    // The keystream entry was read before the second write of the swap, so the
    // two swapped places are taken from the registers rather than the memory.
    always_comb begin
        if (r_t == r_j) begin
            w_ks = r_si;
        end else if (r_t == r_i) begin
            w_ks = r_sj;
        end else begin
            w_ks = w_rdata;
        end
    end

    always_comb begin
        n_i         = r_i;
        n_j         = r_j;
        n_kpos      = r_kpos;
        n_si        = r_si;
        n_sj        = r_sj;
        n_t         = r_t;
        n_data      = r_data;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_we        = 1'b0;
        w_waddr     = r_i;
        w_wdata     = r_si;
        w_raddr     = r_i;
        unique case (i_cmd)
            CMD_NONE: begin
            end
            CMD_LOAD_SCHED: begin
                n_data = i_data;
                n_i    = '0;
                n_j    = '0;
                n_kpos = '0;
            end
            CMD_LOAD_GEN: begin
                n_data = i_data;
            end
            CMD_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_i;
                n_i     = r_i + 8'd1;
            end
            CMD_KS_RD_K: begin
                w_raddr = r_i;
            end
            CMD_KS_RD_J: begin
                n_si    = w_rdata;
                n_j     = r_j + w_rdata + w_key_byte;
                w_raddr = n_j;
                n_kpos  = w_kpos_wrap ? '0 : r_kpos + KPOS_W'(1);
            end
            CMD_KS_WR_K: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = w_rdata;
            end
            CMD_KS_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
                n_i     = r_i + 8'd1;
                if (r_i == 8'hFF) begin
                    n_j = '0;
                end
            end
            CMD_GEN_RD_I: begin
                n_i     = r_i + 8'd1;
                w_raddr = n_i;
            end
            CMD_GEN_RD_J: begin
                n_si    = w_rdata;
                n_j     = r_j + w_rdata;
                w_raddr = n_j;
            end
            CMD_GEN_WR_I: begin
                n_sj    = w_rdata;
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = w_rdata;
                n_t     = r_si + w_rdata;
                w_raddr = n_t;
            end
            CMD_GEN_WR_J: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
                w_raddr = r_t;
                if (w_out_free) begin
                    n_out       = r_data ^ w_ks;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0]    <= '0;
            r_key[1]    <= '0;
            r_key[2]    <= '0;
            r_key[3]    <= '0;
            r_key_len   <= LEN_W'(1);
            r_i         <= '0;
            r_j         <= '0;
            r_kpos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KEY_BYTES_0_7:   r_key[0]  <= i_cfg_data;
                    CFG_KEY_BYTES_8_15:  r_key[1]  <= i_cfg_data;
                    CFG_KEY_BYTES_16_23: r_key[2]  <= i_cfg_data;
                    CFG_KEY_BYTES_24_31: r_key[3]  <= i_cfg_data;
                    CFG_KEY_LENGTH:      r_key_len <= i_cfg_data[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_i         <= n_i;
            r_j         <= n_j;
            r_kpos      <= n_kpos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si   <= n_si;
        r_sj   <= n_sj;
        r_t    <= n_t;
        r_data <= n_data;
        r_out  <= n_out;
    end

    assign o_status.i_last   = (r_i == 8'hFF);
    assign o_status.out_free = w_out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

/* hdl/rc4_stream_cipher.sv */
// Top level of the RC4 stream cipher: controller plus datapath.
// Depends on rc4_pkg, rc4_ctrl, rc4_dp (and rc4_ram through rc4_dp).
//
//   Channel   Direction  Request contents
//   s_axis    in         tdata = data_in[7:0]; tuser = first_of_message
//   m_axis    out        tdata = data_out[7:0]
//   i_cfg_*   in         register index (0..4) and write data, no read-back
//
// A byte that continues a message goes from the accepting idle state through the
// generator steps read i, read j, write i and write j, set by the single read and
// single write port of the permutation memory; the next byte waits for idle.
// A first byte, or any byte before a schedule has run, adds fill and key schedule.
// Reset is synchronous and active low; the permutation is filled before use.
// The result waits in an output register; only the last generator step stalls.
module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Input requests.
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,   // [7:0] data_in
    input  logic                    s_axis_tuser,   // [0] first_of_message
    // Result requests.
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [7:0]              m_axis_tdata,   // [7:0] data_out
    // Configuration writes.
    input  logic                    i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd       w_cmd;
    t_dp_status w_status;

    // The controller owns sequencing and the "schedule has run" flag.
    rc4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_first    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the key, indices, permutation and output register.
    rc4_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_data      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
